[src/tps_pkg.sv]
package tps_pkg;

  localparam logic [2:0] ACT_STEP_WR  = 3'd0;
  localparam logic [2:0] ACT_STAGE_WR = 3'd1;
  localparam logic [2:0] ACT_START    = 3'd2;
  localparam logic [2:0] ACT_SAMPLE   = 3'd3;
  localparam logic [2:0] ACT_TICK     = 3'd4;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 15;

  localparam logic [CFG_IDX_W-1:0] CFG_STAGE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_BAND    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_SAMPLES = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TICKS_PER_UNIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CAPTURE_LEAD   = 3'd4;

  localparam logic [3:0]  RST_STAGE_COUNT    = 4'd1;
  localparam logic [14:0] RST_SETTLE_BAND    = 15'd100;
  localparam logic [3:0]  RST_SETTLE_SAMPLES = 4'd5;
  localparam logic [3:0]  RST_TICKS_PER_UNIT = 4'd10;
  localparam logic [7:0]  RST_CAPTURE_LEAD   = 8'd8;

  // one step entry: hold time above target temperature
  localparam int ENTRY_W = 32;
  localparam int TIMER_W = 20;

  typedef struct packed {
    logic [2:0]         action;
    logic signed [15:0] sample_temp;
    logic [2:0]         entry_stage;
    logic [2:0]         entry_step;
    logic signed [15:0] entry_temp;
    logic [15:0]        entry_hold;
    logic [3:0]         stage_step_count;
    logic [7:0]         stage_repeat_count;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] control_target;
    logic               target_update;
    logic signed [15:0] holding_temp;
    logic               capture_event;
    logic               run_active;
    logic               run_finished;
    logic [3:0]         stage_now;
    logic [3:0]         step_now;
  } out_item_t;

  typedef struct packed {
    logic [3:0]  stage_count;
    logic [14:0] settle_band;
    logic [3:0]  settle_samples;
    logic [3:0]  ticks_per_unit;
    logic [7:0]  capture_lead;
  } cfg_t;

endpackage

[src/thermal_profile_sequencer.sv]
// thermal profile sequencer
// input channel (in_valid/in_ready/in_data) takes one item per cycle: a step
// table write, a stage header write, a run start, a temperature sample or a
// timer tick. every item gives exactly one result item on the out_ channel.
// an accepted item waits in the input register and its result is then
// registered in the result register, from which it shows on out_data.
// throughput: one item per cycle while out_ready is high, set by the single
// pass of sequencer logic between the input and result registers; the step
// table read for the current slot is issued from the next-state indexes.
// a stalled receiver holds the result register; one more item waits in the
// input register, after which in_ready drops until out_ready returns.
// configuration registers are written on cfg_wr_en/cfg_index/cfg_wdata with
// no wait; only while no item is in flight, a rule the block does not enforce.
// reset (rst_n low, synchronous) empties both registers, stops the run and
// the timers and loads the register defaults; the step and stage tables keep
// undefined contents until written and need no clearing pass.
module thermal_profile_sequencer #(
  parameter int MAX_STAGES = 8,
  parameter int MAX_STEPS  = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tps_pkg::in_item_t              in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tps_pkg::out_item_t             out_data,
  input  logic                           cfg_wr_en,
  input  logic [tps_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tps_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DEPTH  = MAX_STAGES * MAX_STEPS;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  tps_pkg::in_item_t  in_item_r;
  logic               in_vld_r;
  tps_pkg::out_item_t out_item_r;
  logic               out_vld_r;
  logic               fire;

  tps_pkg::cfg_t      cfg;
  tps_pkg::out_item_t res;
  logic                        ram_we;
  logic [SLOT_W-1:0]           ram_waddr, ram_raddr;
  logic [tps_pkg::ENTRY_W-1:0] ram_wdata, ram_rdata;

  assign fire     = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      in_vld_r  <= (in_valid && in_ready) || (in_vld_r && !fire);
      out_vld_r <= fire || (out_vld_r && !out_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_data;
    end
    if (fire) begin
      out_item_r <= res;
    end
  end

  tps_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  tps_ram #(
    .WIDTH (tps_pkg::ENTRY_W),
    .DEPTH (DEPTH)
  ) u_step_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (ram_raddr),
    .rd_data (ram_rdata)
  );

  tps_seq #(
    .MAX_STAGES (MAX_STAGES),
    .MAX_STEPS  (MAX_STEPS)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .item      (in_item_r),
    .cfg       (cfg),
    .slot_data (ram_rdata),
    .res       (res),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr)
  );

  assign out_valid = out_vld_r;
  assign out_data  = out_item_r;

endmodule

[src/tps_ram.sv]
module tps_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                                   clk,
  input  logic                                   wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                       wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                       rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    // write-first on an address match
    if (wr_en && (wr_addr == rd_addr)) begin
      rd_data_r <= wr_data;
    end else begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

[src/tps_cfg.sv]
module tps_cfg (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               wr_en,
  input  logic [tps_pkg::CFG_IDX_W-1:0]      index,
  input  logic [tps_pkg::CFG_DATA_W-1:0]     wdata,
  output tps_pkg::cfg_t                      cfg
);

  tps_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.stage_count    <= tps_pkg::RST_STAGE_COUNT;
      cfg_r.settle_band    <= tps_pkg::RST_SETTLE_BAND;
      cfg_r.settle_samples <= tps_pkg::RST_SETTLE_SAMPLES;
      cfg_r.ticks_per_unit <= tps_pkg::RST_TICKS_PER_UNIT;
      cfg_r.capture_lead   <= tps_pkg::RST_CAPTURE_LEAD;
    end else if (wr_en) begin
      case (index)
        tps_pkg::CFG_STAGE_COUNT:    cfg_r.stage_count    <= wdata[3:0];
        tps_pkg::CFG_SETTLE_BAND:    cfg_r.settle_band    <= wdata[14:0];
        tps_pkg::CFG_SETTLE_SAMPLES: cfg_r.settle_samples <= wdata[3:0];
        tps_pkg::CFG_TICKS_PER_UNIT: cfg_r.ticks_per_unit <= wdata[3:0];
        tps_pkg::CFG_CAPTURE_LEAD:   cfg_r.capture_lead   <= wdata[7:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

[src/tps_seq.sv]
module tps_seq #(
  parameter int MAX_STAGES = 8,
  parameter int MAX_STEPS  = 8
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  fire,
  input  tps_pkg::in_item_t                     item,
  input  tps_pkg::cfg_t                         cfg,
  input  logic [tps_pkg::ENTRY_W-1:0]           slot_data,
  output tps_pkg::out_item_t                    res,
  output logic                                  ram_we,
  output logic [((MAX_STAGES * MAX_STEPS > 1) ?
                 $clog2(MAX_STAGES * MAX_STEPS) : 1)-1:0] ram_waddr,
  output logic [tps_pkg::ENTRY_W-1:0]           ram_wdata,
  output logic [((MAX_STAGES * MAX_STEPS > 1) ?
                 $clog2(MAX_STAGES * MAX_STEPS) : 1)-1:0] ram_raddr
);

  localparam int DEPTH  = MAX_STAGES * MAX_STEPS;
  localparam int SLOT_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int STG_W  = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
  localparam int STP_W  = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
  localparam int TW     = tps_pkg::TIMER_W;

  logic [3:0]        steps_tab_r [MAX_STAGES];
  logic [7:0]        reps_tab_r  [MAX_STAGES];

  logic              running_r, running_nxt;
  logic [3:0]        stage_r, stage_nxt;
  logic [3:0]        step_r, step_nxt;
  logic [7:0]        rep_r, rep_nxt;
  logic [3:0]        settle_r, settle_nxt;
  logic [TW-1:0]     hold_rem_r, hold_rem_nxt;
  logic              hold_act_r, hold_act_nxt;
  logic [TW-1:0]     cap_rem_r, cap_rem_nxt;
  logic              cap_act_r, cap_act_nxt;
  logic signed [15:0] held_r, held_nxt;

  logic              upd, cap, fin;
  logic              step_wr_ok, stage_wr_ok;
  logic signed [15:0] target;
  logic [15:0]       hold_units;
  logic signed [16:0] diff;
  logic [16:0]       mag;
  logic              out_band;
  logic [3:0]        settle_inc;
  logic [TW-1:0]     hold_ticks, cap_ticks;
  logic [STG_W-1:0]  cur_stg;
  logic [4:0]        steps_eff, stages_eff;
  logic [4:0]        step_inc, stage_inc;
  logic [8:0]        rep_inc;
  logic [STG_W-1:0]  rd_stg;
  logic [STP_W-1:0]  rd_stp;

  assign step_wr_ok  = ({2'b0, item.entry_stage} < 5'(MAX_STAGES)) &&
                       ({2'b0, item.entry_step} < 5'(MAX_STEPS));
  assign stage_wr_ok = ({2'b0, item.entry_stage} < 5'(MAX_STAGES));

  assign ram_we    = fire && (item.action == tps_pkg::ACT_STEP_WR) && step_wr_ok;
  assign ram_waddr = SLOT_W'(9'(item.entry_stage) * 9'(MAX_STEPS) + 9'(item.entry_step));
  assign ram_wdata = {item.entry_hold, item.entry_temp};

  // sample path
  assign target     = slot_data[15:0];
  assign hold_units = slot_data[31:16];
  assign diff       = {item.sample_temp[15], item.sample_temp} - {target[15], target};
  assign mag        = diff[16] ? 17'(-diff) : 17'(diff);
  assign out_band   = mag > {2'b0, cfg.settle_band};
  assign settle_inc = settle_r + 4'd1;
  assign hold_ticks = TW'(hold_units) * TW'(cfg.ticks_per_unit);
  assign cap_ticks  = (hold_units > {8'b0, cfg.capture_lead}) ?
                      TW'(hold_units - {8'b0, cfg.capture_lead}) * TW'(cfg.ticks_per_unit) :
                      '0;

  // step advance
  assign cur_stg    = ({1'b0, stage_r} < 5'(MAX_STAGES)) ? STG_W'(stage_r) :
                      STG_W'(MAX_STAGES - 1);
  assign steps_eff  = ({1'b0, steps_tab_r[cur_stg]} > 5'(MAX_STEPS)) ? 5'(MAX_STEPS) :
                      {1'b0, steps_tab_r[cur_stg]};
  assign stages_eff = ({1'b0, cfg.stage_count} > 5'(MAX_STAGES)) ? 5'(MAX_STAGES) :
                      {1'b0, cfg.stage_count};
  assign step_inc   = {1'b0, step_r} + 5'd1;
  assign stage_inc  = {1'b0, stage_r} + 5'd1;
  assign rep_inc    = {1'b0, rep_r} + 9'd1;

  always_comb begin
    running_nxt  = running_r;
    stage_nxt    = stage_r;
    step_nxt     = step_r;
    rep_nxt      = rep_r;
    settle_nxt   = settle_r;
    hold_rem_nxt = hold_rem_r;
    hold_act_nxt = hold_act_r;
    cap_rem_nxt  = cap_rem_r;
    cap_act_nxt  = cap_act_r;
    held_nxt     = held_r;
    upd          = 1'b0;
    cap          = 1'b0;
    fin          = 1'b0;
    if (fire) begin
      case (item.action)
        tps_pkg::ACT_START: begin
          running_nxt  = 1'b1;
          stage_nxt    = '0;
          step_nxt     = '0;
          rep_nxt      = '0;
          settle_nxt   = '0;
          hold_rem_nxt = '0;
          hold_act_nxt = 1'b0;
          cap_rem_nxt  = '0;
          cap_act_nxt  = 1'b0;
          held_nxt     = '0;
        end
        tps_pkg::ACT_SAMPLE: begin
          if (running_r) begin
            if (out_band) begin
              settle_nxt = '0;
              upd        = 1'b1;
              held_nxt   = '0;
            end else if (settle_inc >= cfg.settle_samples) begin
              settle_nxt = '0;
              held_nxt   = target;
              if (!hold_act_r) begin
                hold_rem_nxt = hold_ticks;
                hold_act_nxt = 1'b1;
                cap_rem_nxt  = cap_ticks;
                cap_act_nxt  = 1'b1;
              end
            end else begin
              settle_nxt = settle_inc;
            end
          end
        end
        tps_pkg::ACT_TICK: begin
          if (cap_act_r) begin
            if (cap_rem_r <= TW'(1)) begin
              cap_rem_nxt = '0;
              cap_act_nxt = 1'b0;
              cap         = 1'b1;
            end else begin
              cap_rem_nxt = cap_rem_r - TW'(1);
            end
          end
          if (hold_act_r) begin
            if (hold_rem_r <= TW'(1)) begin
              hold_act_nxt = 1'b0;
              hold_rem_nxt = '0;
              if (running_r) begin
                if (step_inc >= steps_eff) begin
                  if (rep_inc >= {1'b0, reps_tab_r[cur_stg]}) begin
                    rep_nxt   = '0;
                    stage_nxt = stage_inc[3:0];
                    if (stage_inc >= stages_eff) begin
                      running_nxt = 1'b0;
                      fin         = 1'b1;
                      step_nxt    = step_inc[3:0];
                    end else begin
                      step_nxt = '0;
                    end
                  end else begin
                    rep_nxt  = rep_inc[7:0];
                    step_nxt = '0;
                  end
                end else begin
                  step_nxt = step_inc[3:0];
                end
              end
            end else begin
              hold_rem_nxt = hold_rem_r - TW'(1);
            end
          end
        end
        default: ;
      endcase
    end
  end

  // read the slot of the state the next item sees
  assign rd_stg    = ({1'b0, stage_nxt} < 5'(MAX_STAGES)) ? STG_W'(stage_nxt) :
                     STG_W'(MAX_STAGES - 1);
  assign rd_stp    = ({1'b0, step_nxt} < 5'(MAX_STEPS)) ? STP_W'(step_nxt) :
                     STP_W'(MAX_STEPS - 1);
  assign ram_raddr = SLOT_W'(9'(rd_stg) * 9'(MAX_STEPS) + 9'(rd_stp));

  always_ff @(posedge clk) begin
    if (fire && (item.action == tps_pkg::ACT_STAGE_WR) && stage_wr_ok) begin
      steps_tab_r[STG_W'(item.entry_stage)] <= item.stage_step_count;
      reps_tab_r[STG_W'(item.entry_stage)]  <= item.stage_repeat_count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r  <= 1'b0;
      stage_r    <= '0;
      step_r     <= '0;
      rep_r      <= '0;
      settle_r   <= '0;
      hold_rem_r <= '0;
      hold_act_r <= 1'b0;
      cap_rem_r  <= '0;
      cap_act_r  <= 1'b0;
      held_r     <= '0;
    end else begin
      running_r  <= running_nxt;
      stage_r    <= stage_nxt;
      step_r     <= step_nxt;
      rep_r      <= rep_nxt;
      settle_r   <= settle_nxt;
      hold_rem_r <= hold_rem_nxt;
      hold_act_r <= hold_act_nxt;
      cap_rem_r  <= cap_rem_nxt;
      cap_act_r  <= cap_act_nxt;
      held_r     <= held_nxt;
    end
  end

  always_comb begin
    res.control_target = upd ? target : 16'sd0;
    res.target_update  = upd;
    res.holding_temp   = held_nxt;
    res.capture_event  = cap;
    res.run_active     = running_nxt;
    res.run_finished   = fin;
    res.stage_now      = stage_nxt;
    res.step_now       = step_nxt;
  end

endmodule

[src/tps_check.sv]
module tps_check (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input tps_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result item changed or dropped");

  a_update_running: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.target_update |-> out_data.run_active)
    else $error("target update while not running");

  a_finish_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.run_finished |-> !out_data.run_active &&
    !out_data.target_update)
    else $error("run finished but still active");

  a_target_only_on_update: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.target_update |-> out_data.control_target == 16'sd0)
    else $error("control target without update");

endmodule

bind thermal_profile_sequencer tps_check u_tps_check (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
